// ----- src/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions of the text console writer
// Field widths, cell constants, special characters and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // Widths of the channel fields.
    localparam int CMD_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // A blank cell is a space with attribute 7.
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    // Characters with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

    // Command codes of an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_command;

endpackage

`default_nettype wire

// ----- src/tcw_if.sv -----
// ----------------------------------------------------------------------------
// tcw_if: channel interfaces of the text console writer
// Command, result and attribute-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_cmd_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_col;

    modport source (output valid, command, char_code, cell_row, cell_col, input ready);
    modport sink   (input valid, command, char_code, cell_row, cell_col, output ready);
endinterface

interface tcw_res_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;

    modport source (output valid, cursor_row, cursor_col, cell_value, scrolled, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cell_value, scrolled, output ready);
endinterface

interface tcw_cfg_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_attribute;

    modport source (output valid, text_attribute, input ready);
    modport sink   (input valid, text_attribute, output ready);
endinterface

`default_nettype wire

// ----- src/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Screen store of ROWS x COLUMNS cells with a cursor, put/read/clear commands.
// ----------------------------------------------------------------------------
// Usage:
// - i_cmd takes one command per transfer: put a character, read a cell, or
//   clear the screen. o_res returns one result per command: the cursor after
//   the command, the read cell (zero for other commands) and a scroll flag.
// - i_cfg writes the attribute byte used for put; it is always ready. Write it
//   only while no command is in progress; the block does not enforce this.
// - A plain put or an unused command passes S_EXEC before its result is set,
//   and a new command is taken only once the block is back in S_IDLE. A read
//   inside the screen also passes S_RDATA, which waits on the registered read
//   port of the cell store; a read outside the screen does not.
// - Clear and scroll walk the store one cell per cycle through its single
//   write port: clear blanks every cell, a put that scrolls copies each cell
//   one row up and then blanks the bottom row.
// - After reset the store is blanked in a pass over all ROWS*COLUMNS cells
//   (2000 by default) during which i_cmd is not ready; the cursor is at row 0,
//   column 0 and the attribute is 7.
// - One command may be taken while a result waits on o_res; its work starts
//   when the result slot is free, so a stalled receiver holds the block.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_cmd_if.sink   i_cmd,
    tcw_res_if.source o_res,
    tcw_cfg_if.sink   i_cfg
);
    import tcw_pkg::*;

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    logic [ATTR_W-1:0] r_attr;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // Attribute register, written on every configuration transfer.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= RESET_ATTR;
        end else if (i_cfg.valid) begin
            r_attr <= i_cfg.text_attribute;
        end
    end

    // Command sequencer.
    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .i_attr      (r_attr),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Screen cell store.
    tcw_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// ----- src/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram: screen cell store
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter  int DEPTH = tcw_pkg::DEF_ROWS * tcw_pkg::DEF_COLUMNS,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [tcw_pkg::CELL_W-1:0] o_rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- src/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl: command sequencer of the text console writer
// Moves the cursor, writes cells, and walks the store for clear and scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl #(
    parameter  int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter  int ROWS    = tcw_pkg::DEF_ROWS,
    localparam int DEPTH   = ROWS * COLUMNS,
    localparam int AW      = $clog2(DEPTH)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    tcw_cmd_if.sink                         i_cmd,
    tcw_res_if.source                       o_res,
    input  wire logic [tcw_pkg::ATTR_W-1:0] i_attr,
    output logic                            o_ram_we,
    output logic      [AW-1:0]              o_ram_waddr,
    output logic      [tcw_pkg::CELL_W-1:0] o_ram_wdata,
    output logic                            o_ram_re,
    output logic      [AW-1:0]              o_ram_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] i_ram_rdata
);
    import tcw_pkg::*;

    localparam int RW   = $clog2(ROWS);
    localparam int CW   = $clog2(COLUMNS);
    localparam int LAST = (ROWS - 1) * COLUMNS;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_SCROLL,
        S_BLANK
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_addr;
    logic              r_fill_result;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic              r_out_valid;
    logic [CELL_W-1:0] r_value;
    logic              r_scrolled;
    logic              r_cp_wen;
    logic [AW-1:0]     r_cp_addr;

    logic [CMD_W-1:0]  r_in_cmd;
    logic [CHAR_W-1:0] r_in_char;
    logic [ROW_W-1:0]  r_in_row;
    logic [COL_W-1:0]  r_in_col;

    logic              slot_free;
    logic              is_bs;
    logic              is_nl;
    logic              last_col;
    logic              last_row;
    logic              read_ok;
    logic [CW-1:0]     put_col;
    logic [AW-1:0]     cursor_addr;
    logic [AW-1:0]     read_addr;

    // The result slot can be loaded when it is empty or taken this cycle.
    assign slot_free = !r_out_valid || o_res.ready;

    assign is_bs    = (r_in_char == CH_BACKSPACE);
    assign is_nl    = (r_in_char == CH_NEWLINE);
    assign last_col = (r_col == CW'(COLUMNS - 1));
    assign last_row = (r_row == RW'(ROWS - 1));
    assign read_ok  = (int'(r_in_row) < ROWS) && (int'(r_in_col) < COLUMNS);

    // Backspace writes one column to the left of the cursor.
    assign put_col     = is_bs ? (r_col - CW'(1)) : r_col;
    assign cursor_addr = AW'(AW'(r_row) * AW'(COLUMNS) + AW'(put_col));
    assign read_addr   = AW'(AW'(r_in_row) * AW'(COLUMNS) + AW'(r_in_col));

    // Channel outputs.
    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.cursor_row = ROW_W'(r_row);
    assign o_res.cursor_col = COL_W'(r_col);
    assign o_res.cell_value = r_value;
    assign o_res.scrolled   = r_scrolled;

    // Store port control; a pending scroll copy owns the write port.
    always_comb begin
        o_ram_we    = 1'b0;
        o_ram_waddr = r_addr;
        o_ram_wdata = BLANK_CELL;
        o_ram_re    = 1'b0;
        o_ram_raddr = AW'(r_addr + AW'(COLUMNS));
        if (r_cp_wen) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_cp_addr;
            o_ram_wdata = i_ram_rdata;
        end else begin
            case (r_state)
                S_FILL, S_BLANK: begin
                    o_ram_we = 1'b1;
                end
                S_EXEC: begin
                    if (slot_free && r_in_cmd == CMD_PUT && !is_nl &&
                        (!is_bs || r_col != '0)) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = cursor_addr;
                        o_ram_wdata = is_bs ? BLANK_CELL : {i_attr, r_in_char};
                    end
                end
                default: begin
                end
            endcase
        end
        if (r_state == S_SCROLL) begin
            o_ram_re = 1'b1;
        end else if (r_state == S_EXEC && slot_free && r_in_cmd == CMD_READ && read_ok) begin
            o_ram_re    = 1'b1;
            o_ram_raddr = read_addr;
        end
    end

    // Sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_FILL;
            r_addr        <= '0;
            r_fill_result <= 1'b0;
            r_row         <= '0;
            r_col         <= '0;
            r_out_valid   <= 1'b0;
            r_cp_wen      <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            r_cp_wen <= 1'b0;
            case (r_state)
                // Blank every cell, after reset and for the clear command.
                S_FILL: begin
                    if (r_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                        if (r_fill_result) begin
                            r_out_valid <= 1'b1;
                            r_value     <= '0;
                            r_scrolled  <= 1'b0;
                        end
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end

                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_in_cmd  <= i_cmd.command;
                        r_in_char <= i_cmd.char_code;
                        r_in_row  <= i_cmd.cell_row;
                        r_in_col  <= i_cmd.cell_col;
                        r_state   <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    if (slot_free) begin
                        r_value    <= '0;
                        r_scrolled <= 1'b0;
                        case (t_command'(r_in_cmd))
                            CMD_PUT: begin
                                if (is_bs) begin
                                    if (r_col != '0) begin
                                        r_col <= r_col - CW'(1);
                                    end
                                    r_out_valid <= 1'b1;
                                    r_state     <= S_IDLE;
                                end else if (is_nl || last_col) begin
                                    r_col <= '0;
                                    if (last_row) begin
                                        // Moving past the bottom row scrolls.
                                        r_addr  <= '0;
                                        r_state <= S_SCROLL;
                                    end else begin
                                        r_row       <= r_row + RW'(1);
                                        r_out_valid <= 1'b1;
                                        r_state     <= S_IDLE;
                                    end
                                end else begin
                                    r_col       <= r_col + CW'(1);
                                    r_out_valid <= 1'b1;
                                    r_state     <= S_IDLE;
                                end
                            end
                            CMD_READ: begin
                                if (read_ok) begin
                                    r_state <= S_RDATA;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_state     <= S_IDLE;
                                end
                            end
                            CMD_CLEAR: begin
                                r_row         <= '0;
                                r_col         <= '0;
                                r_addr        <= '0;
                                r_fill_result <= 1'b1;
                                r_state       <= S_FILL;
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_state     <= S_IDLE;
                            end
                        endcase
                    end
                end

                // The read cell arrives from the registered read port in the cycle after its address.
                S_RDATA: begin
                    r_value     <= i_ram_rdata;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end

                // Copy each cell one row up: read below, write in the next cycle.
                S_SCROLL: begin
                    r_cp_wen  <= 1'b1;
                    r_cp_addr <= r_addr;
                    if (r_addr == AW'(LAST - 1)) begin
                        r_addr  <= AW'(LAST);
                        r_state <= S_BLANK;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end

                // Blank the bottom row once the last copy has been written.
                S_BLANK: begin
                    if (!r_cp_wen) begin
                        if (r_addr == AW'(DEPTH - 1)) begin
                            r_out_valid <= 1'b1;
                            r_scrolled  <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_addr <= r_addr + AW'(1);
                        end
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- tb/text_console_writer_checker.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_checker: result checker of the text console writer
// Watches the command, result and attribute channels, keeps its own copy of
// the screen, cursor and attribute, predicts the report of every command
// transfer and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module text_console_writer_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcw_cmd_if        i_cmd,
    tcw_res_if        i_res,
    tcw_cfg_if        i_cfg,
    output int        o_error_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    // One cursor report as it is expected on the result channel.
    typedef struct packed {
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_value;
        logic              scrolled;
    } t_console_report;

    // Predicted screen, cursor and attribute.
    logic [CELL_W-1:0] screen [ROWS][COLUMNS];
    int                cur_row;
    int                cur_col;
    logic [ATTR_W-1:0] text_attr;

    // Reports predicted for accepted commands, oldest first.
    t_console_report   cursor_reports [$];
    int                mismatches = 0;

    function automatic void blank_screen();
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                screen[r][c] = BLANK_CELL;
            end
        end
    endfunction

    // Applies one command to the predicted console and returns its report.
    function automatic t_console_report advance_console(
        input logic [CMD_W-1:0]  code,
        input logic [CHAR_W-1:0] ch,
        input logic [ROW_W-1:0]  rd_row,
        input logic [COL_W-1:0]  rd_col
    );
        t_console_report report;
        report = '0;
        case (code)
            CMD_PUT: begin
                if (ch == CH_BACKSPACE) begin
                    // Backspace blanks the cell to the left; at column 0 it is ignored.
                    if (cur_col > 0) begin
                        cur_col--;
                        screen[cur_row][cur_col] = BLANK_CELL;
                    end
                end else begin
                    if (ch == CH_NEWLINE) begin
                        cur_row++;
                        cur_col = 0;
                    end else begin
                        screen[cur_row][cur_col] = {text_attr, ch};
                        cur_col++;
                    end
                    // Wrap past the last column.
                    if (cur_col >= COLUMNS) begin
                        cur_col = 0;
                        cur_row++;
                    end
                    // Past the last row, everything moves up one row.
                    if (cur_row >= ROWS) begin
                        for (int r = 0; r < ROWS - 1; r++) begin
                            for (int c = 0; c < COLUMNS; c++) begin
                                screen[r][c] = screen[r + 1][c];
                            end
                        end
                        for (int c = 0; c < COLUMNS; c++) begin
                            screen[ROWS - 1][c] = BLANK_CELL;
                        end
                        cur_row = ROWS - 1;
                        report.scrolled = 1'b1;
                    end
                end
            end
            CMD_READ: begin
                // Reads outside the screen return zero.
                if (rd_row < ROWS && rd_col < COLUMNS) begin
                    report.cell_value = screen[rd_row][rd_col];
                end
            end
            CMD_CLEAR: begin
                blank_screen();
                cur_row = 0;
                cur_col = 0;
            end
            default: begin
                // The unused code only reports the cursor.
            end
        endcase
        report.cursor_row = ROW_W'(cur_row);
        report.cursor_col = COL_W'(cur_col);
        return report;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Every transfer is handled at the clock edge that completes it.
    always @(posedge i_clk) begin
        t_console_report want;
        if (!i_rst_n) begin
            blank_screen();
            cur_row = 0;
            cur_col = 0;
            text_attr = RESET_ATTR;
            cursor_reports.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                text_attr = i_cfg.text_attribute;
            end

            // A result transfer is matched against the oldest prediction.
            if (i_res.valid && i_res.ready) begin
                if (cursor_reports.size() == 0) begin
                    $error("result transfer with no command waiting: row %0d col %0d",
                           i_res.cursor_row, i_res.cursor_col);
                    mismatches++;
                end else begin
                    want = cursor_reports.pop_front();
                    compare_field("cursor_row", 32'(want.cursor_row),
                                  32'(i_res.cursor_row));
                    compare_field("cursor_col", 32'(want.cursor_col),
                                  32'(i_res.cursor_col));
                    compare_field("cell_value", 32'(want.cell_value),
                                  32'(i_res.cell_value));
                    compare_field("scrolled", 32'(want.scrolled), 32'(i_res.scrolled));
                end
            end

            if (i_cmd.valid && i_cmd.ready) begin
                cursor_reports.push_back(advance_console(i_cmd.command, i_cmd.char_code,
                                                         i_cmd.cell_row, i_cmd.cell_col));
            end
        end
        o_pending     <= cursor_reports.size();
        o_error_count <= mismatches;
    end

endmodule

// ----- tb/text_console_writer_test.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_test: top of the text console writer testbench
// Drives directed and random command streams with random idling on both
// channels, rewrites the text attribute between phases and leaves prediction
// and comparison to the checker beside the block.
// ----------------------------------------------------------------------------
module text_console_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS          = DEF_COLUMNS;
    localparam int ROWS             = DEF_ROWS;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 305;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int SETTLE_CYCLES    = 40;

    // Command code that the block does not use.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tcw_cmd_if cmd_ch ();
    tcw_res_if res_ch ();
    tcw_cfg_if cfg_ch ();

    int error_count;
    int pending;
    int items_sent = 0;
    int phase_end  = 0;
    int idle_cycles = 0;
    bit sender_idles      = 1'b1;
    bit receiver_stalls   = 1'b1;
    bit long_hold_request = 1'b0;

    text_console_writer #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    text_console_writer_checker #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .i_cfg        (cfg_ch),
        .o_error_count(error_count),
        .o_pending    (pending)
    );

    // Clock with a 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result receiver: random stall bursts, and one long hold-off on request.
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Random field values over the whole width of each field.
    function automatic logic [CHAR_W-1:0] any_char();
        return CHAR_W'($urandom());
    endfunction

    function automatic logic [ROW_W-1:0] any_row();
        return ROW_W'($urandom());
    endfunction

    function automatic logic [COL_W-1:0] any_col();
        return COL_W'($urandom());
    endfunction

    // Offers one command, after an optional idle burst, until it is transferred.
    task automatic send_item(input logic [CMD_W-1:0] code, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        if (sender_idles && $urandom_range(0, 5) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.command   <= code;
        cmd_ch.char_code <= ch;
        cmd_ch.cell_row  <= row;
        cmd_ch.cell_col  <= col;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        items_sent++;
    endtask

    // Stops offering and waits until every predicted result has been transferred.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.text_attribute <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
    endtask

    // One line of text with random content, interleaved with reads, backspaces
    // and unused commands; most lines end in a newline, some are left open.
    task automatic send_text_line();
        int length;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            length = $urandom_range(0, 10);
        end else if (pick < 9) begin
            length = $urandom_range(11, COLUMNS - 1);
        end else begin
            length = $urandom_range(COLUMNS, 2 * COLUMNS + 10);
        end
        for (int i = 0; i < length && items_sent < phase_end; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_item(CMD_PUT, CH_BACKSPACE, any_row(), any_col());
            end else if (pick < 12) begin
                // Read anywhere the fields reach, mostly outside the screen.
                send_item(CMD_READ, any_char(), any_row(), any_col());
            end else if (pick < 17) begin
                // Read near the bottom, where text is being written.
                send_item(CMD_READ, any_char(), ROW_W'($urandom_range(ROWS - 4, ROWS - 1)),
                          COL_W'($urandom_range(0, COLUMNS - 1)));
            end else if (pick < 22) begin
                send_item(CMD_READ, any_char(), ROW_W'($urandom_range(0, ROWS - 1)),
                          COL_W'($urandom_range(0, COLUMNS - 1)));
            end else if (pick < 24) begin
                send_item(CMD_UNUSED, any_char(), any_row(), any_col());
            end else begin
                send_item(CMD_PUT, any_char(), any_row(), any_col());
            end
        end
        if ($urandom_range(0, 9) != 0) begin
            send_item(CMD_PUT, CH_NEWLINE, any_row(), any_col());
        end
    endtask

    // Stimulus: reset, a directed opening, then random phases per attribute.
    initial begin
        logic [ATTR_W-1:0] attr;
        cmd_ch.valid          <= 1'b0;
        cmd_ch.command        <= CMD_PUT;
        cmd_ch.char_code      <= '0;
        cmd_ch.cell_row       <= '0;
        cmd_ch.cell_col       <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.text_attribute <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening under the reset attribute.
        send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'h41, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'hFF, 5'd31, 7'd127);
        send_item(CMD_PUT, 8'h00, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd1);
        // Backspace in the middle of a row, then read the blanked cell.
        send_item(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd2);
        send_item(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0);
        // Backspace at column 0 changes nothing.
        send_item(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0);
        send_item(CMD_READ, 8'h00, 5'd1, 7'd0);
        // Reads outside the screen and at its last cell.
        send_item(CMD_READ, 8'hFF, 5'd31, 7'd127);
        send_item(CMD_READ, 8'h00, ROW_W'(ROWS), 7'd0);
        send_item(CMD_READ, 8'h00, 5'd0, COL_W'(COLUMNS));
        send_item(CMD_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
        send_item(CMD_UNUSED, 8'hFF, 5'd31, 7'd127);
        send_item(CMD_CLEAR, 8'hFF, 5'd31, 7'd127);
        send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
        send_item(CMD_PUT, 8'h7E, 5'd0, 7'd0);

        // Random phases, each under its own attribute written while idle.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain_results();
            case (phase)
                0:       attr = 8'hFF;
                1:       attr = 8'h00;
                2:       attr = 8'hA5;
                3:       attr = 8'h5A;
                4:       attr = ATTR_W'($urandom_range(0, 255));
                default: attr = RESET_ATTR;
            endcase
            write_attribute(attr);
            sender_idles    = (phase != 3) && (phase != PHASES - 1);
            receiver_stalls = (phase != 1) && (phase != PHASES - 1);
            if (phase == 2) begin
                long_hold_request = 1'b1;
            end
            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 49) == 0) begin
                    send_item(CMD_CLEAR, any_char(), any_row(), any_col());
                end else begin
                    send_text_line();
                end
            end
        end

        // Let the last results arrive, then give the verdict.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
